/* design/postfix_hex_byte_evaluator_unit_assert.svh */
// Assertion macros used by the back end of the evaluator RTL.
`ifndef POSTFIX_HEX_BYTE_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_HEX_BYTE_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PFX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfx assertion failed");

// Next-cycle implication, checked out of reset.
`define PFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfx assertion failed");

`endif

/* design/pfx_pkg.sv */
// Package: shared types, codes and constants of the postfix evaluator.
`timescale 1ns / 1ps
package pfx_pkg;

    localparam int PFX_DATA_W      = 8;
    localparam int PFX_STATUS_W    = 3;
    localparam int PFX_STACK_DEPTH = 128;
    localparam int PFX_QUEUE_DEPTH = 4;

    // Result status codes
    localparam logic [PFX_STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [PFX_STATUS_W-1:0] ST_UNDER   = 3'd1;
    localparam logic [PFX_STATUS_W-1:0] ST_OVER    = 3'd2;
    localparam logic [PFX_STATUS_W-1:0] ST_DIVZ    = 3'd3;
    localparam logic [PFX_STATUS_W-1:0] ST_UNKNOWN = 3'd4;

    // ASCII codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // Command kinds passed from front to back
    typedef logic [2:0] t_kind;
    localparam t_kind K_NONE = 3'd0;
    localparam t_kind K_PUSH = 3'd1;
    localparam t_kind K_ADD  = 3'd2;
    localparam t_kind K_SUB  = 3'd3;
    localparam t_kind K_MUL  = 3'd4;
    localparam t_kind K_DIV  = 3'd5;
    localparam t_kind K_BAD  = 3'd6;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expr;
    } t_in_item;

    typedef struct packed {
        logic [PFX_DATA_W-1:0]   value;
        logic [PFX_STATUS_W-1:0] status;
    } t_out_item;

    typedef struct packed {
        t_kind                 kind;
        logic [PFX_DATA_W-1:0] operand;
        logic                  last;
    } t_cmd;

endpackage

/* design/pfx_front.sv */
// Front end: classify characters, pair hex digits and issue commands.
`timescale 1ns / 1ps
module pfx_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pfx_pkg::t_in_item i_in_item,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output pfx_pkg::t_cmd o_cmd
);
    import pfx_pkg::*;

    logic       r_pending, n_pending;
    logic [3:0] r_high, n_high;
    logic       w_accept;
    logic       w_is_num, w_is_alpha;
    logic [3:0] w_nibble;
    logic [7:0] w_c;

    assign w_c        = i_in_item.char_code;
    assign w_accept   = i_push && !i_q_full;
    assign w_is_num   = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_is_alpha = (w_c >= CH_UA) && (w_c <= CH_UF);

    always_comb begin
        w_nibble = 4'd0;
        if (w_is_num) begin
            w_nibble = 4'(w_c - CH_ZERO);
        end else if (w_is_alpha) begin
            w_nibble = 4'(w_c - CH_UA + 8'd10);
        end
    end

    always_comb begin
        n_pending     = r_pending;
        n_high        = r_high;
        o_cmd.kind    = K_NONE;
        o_cmd.operand = {r_high, w_nibble};
        o_cmd.last    = i_in_item.end_of_expr;
        o_q_wr        = 1'b0;
        if (w_accept) begin
            o_q_wr = 1'b1;
            if (w_is_num || w_is_alpha) begin
                if (!r_pending) begin
                    // first digit of a pair: hold it, nothing to do unless last
                    n_pending = 1'b1;
                    n_high    = w_nibble;
                    o_q_wr    = i_in_item.end_of_expr;
                end else begin
                    n_pending  = 1'b0;
                    o_cmd.kind = K_PUSH;
                end
            end else begin
                unique case (w_c)
                    CH_PLUS:  o_cmd.kind = K_ADD;
                    CH_MINUS: o_cmd.kind = K_SUB;
                    CH_STAR:  o_cmd.kind = K_MUL;
                    CH_SLASH: o_cmd.kind = K_DIV;
                    default:  o_cmd.kind = K_BAD;
                endcase
            end
            if (i_in_item.end_of_expr) begin
                // drop a dangling digit
                n_pending = 1'b0;
                n_high    = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_high    <= 4'd0;
        end else begin
            r_pending <= n_pending;
            r_high    <= n_high;
        end
    end

endmodule

/* design/pfx_queue.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module pfx_queue #(
    parameter int DEPTH = pfx_pkg::PFX_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  pfx_pkg::t_cmd i_wr_cmd,
    input  logic          i_rd,
    output logic          o_full,
    output logic          o_valid,
    output pfx_pkg::t_cmd o_rd_cmd
);
    import pfx_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_fill, n_fill;
    logic          w_wr, w_rd;

    assign o_full   = (r_fill == CW'(DEPTH));
    assign o_valid  = (r_fill != '0);
    assign o_rd_cmd = r_slot[r_head];
    assign w_wr     = i_wr && !o_full;
    assign w_rd     = i_rd && o_valid;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (w_wr) begin
            n_tail = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (w_rd) begin
            n_head = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_fill = r_fill + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_tail] <= i_wr_cmd;
        end
    end

endmodule

/* design/pfx_div.sv */
// Restoring byte divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pfx_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pfx_pkg::PFX_DATA_W-1:0] i_dividend,
    input  logic [pfx_pkg::PFX_DATA_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [pfx_pkg::PFX_DATA_W-1:0] o_quotient
);
    import pfx_pkg::*;

    localparam int SW = $clog2(PFX_DATA_W);

    logic                  r_busy, r_done;
    logic [SW-1:0]         r_step;
    logic [PFX_DATA_W-1:0] r_rem, r_quo, r_dvs;
    logic [PFX_DATA_W:0]   w_trial;
    logic                  w_fit;

    assign w_trial    = {r_rem, r_quo[PFX_DATA_W-1]};
    assign w_fit      = (w_trial >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SW'(PFX_DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? PFX_DATA_W'(w_trial - {1'b0, r_dvs})
                           : w_trial[PFX_DATA_W-1:0];
            r_quo <= {r_quo[PFX_DATA_W-2:0], w_fit};
        end
    end

endmodule

/* design/pfx_back.sv */
// Back end: operand stack, arithmetic, error tracking and result register.
`timescale 1ns / 1ps
`include "postfix_hex_byte_evaluator_unit_assert.svh"
module pfx_back #(
    parameter int STACK_DEPTH = pfx_pkg::PFX_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  pfx_pkg::t_cmd      i_cmd,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_empty,
    output pfx_pkg::t_out_item o_out_item
);
    import pfx_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [PFX_DATA_W-1:0]   r_mem [STACK_DEPTH];
    logic [PFX_DATA_W-1:0]   r_rdata;
    logic [1:0]              r_state, n_state;
    logic [PFX_DATA_W-1:0]   r_top, n_top;
    logic [CW-1:0]           r_count, n_count;
    logic [PFX_STATUS_W-1:0] r_err, n_err;
    logic                    r_out_valid;
    t_out_item               r_out, n_out;
    logic                    w_start, w_retire, w_we;
    logic [AW-1:0]           w_wr_addr, w_rd_addr;
    logic [2*PFX_DATA_W-1:0] w_prod;
    logic                    w_div_start, w_div_done;
    logic [PFX_DATA_W-1:0]   w_quo;

    pfx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rdata),
        .i_divisor  (r_top),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_start   = i_q_valid && (!i_cmd.last || !r_out_valid || i_pop);
    assign w_wr_addr = AW'(r_count - 1'b1);
    assign w_rd_addr = AW'(r_count - CW'(2));
    assign w_prod    = r_rdata * r_top;
    assign o_q_rd    = w_retire;
    assign o_empty   = !r_out_valid;
    assign o_out_item = r_out;

    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_count     = r_count;
        n_err       = r_err;
        w_retire    = 1'b0;
        w_we        = 1'b0;
        w_div_start = 1'b0;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    if (r_err != ST_OK) begin
                        w_retire = 1'b1;
                    end else begin
                        unique case (i_cmd.kind)
                            K_PUSH: begin
                                w_retire = 1'b1;
                                if (r_count >= CW'(STACK_DEPTH)) begin
                                    n_err = ST_OVER;
                                end else begin
                                    w_we    = (r_count != '0);
                                    n_top   = i_cmd.operand;
                                    n_count = r_count + 1'b1;
                                end
                            end
                            K_ADD, K_SUB, K_MUL, K_DIV: begin
                                if (r_count < CW'(2)) begin
                                    n_err    = ST_UNDER;
                                    w_retire = 1'b1;
                                end else begin
                                    n_state = S_EXEC;
                                end
                            end
                            K_BAD: begin
                                n_err    = ST_UNKNOWN;
                                w_retire = 1'b1;
                            end
                            default: begin
                                w_retire = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_count = r_count - 1'b1;
                w_retire = 1'b1;
                unique case (i_cmd.kind)
                    K_ADD: n_top = r_rdata + r_top;
                    K_SUB: n_top = r_rdata - r_top;
                    K_MUL: n_top = w_prod[PFX_DATA_W-1:0];
                    default: begin
                        if (r_top == '0) begin
                            n_err = ST_DIVZ;
                            n_top = '0;
                        end else begin
                            // hand over to the divider and wait
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                            n_count     = r_count;
                            w_retire    = 1'b0;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_top    = w_quo;
                    n_count  = r_count - 1'b1;
                    w_retire = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_retire && i_cmd.last) begin
            n_out.status = n_err;
            n_out.value  = '0;
            if (n_err == ST_OK) begin
                if (n_count == '0) begin
                    n_out.status = ST_UNDER;
                end else begin
                    n_out.value = n_top;
                end
            end
            n_count = '0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            if (w_retire && i_cmd.last) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= r_top;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    `PFX_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH))
    `PFX_ASSERT_NOW(a_exec_operands, i_clk, i_rst_n, r_state != S_IDLE, r_count >= CW'(2))
    `PFX_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_top != '0)
    `PFX_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_retire && i_cmd.last, r_out_valid)

endmodule

/* design/postfix_hex_byte_evaluator_unit.sv */
// Top level of the postfix hex byte evaluator.
`timescale 1ns / 1ps
// Evaluates a postfix expression fed one ASCII character per transaction.
// Pairs of upper-case hex digits (high digit first) form byte operands that
// are pushed on an operand stack of STACK_DEPTH bytes; + - * / pop two bytes
// and push the result modulo 256 (deeper operand on the left). On the
// character flagged end_of_expr one result transaction carries the top of
// the stack and a status (0 ok, 1 underflow, 2 overflow, 3 divide by zero,
// 4 unknown character; value reads 0 whenever status is not ok). The first
// error sticks and the rest of the expression is ignored; after the last
// character the stack, the digit pairing and the error are cleared and a
// dangling single digit is dropped. A front end classifies characters and
// pairs digits, then passes commands through a four-entry queue to the back
// end, which owns the stack. In the back end the first digit of a pair
// needs no work unless it ends the expression; a completed pair is pushed
// from the idle state. + - and * read the second operand from the stack
// (the top sits in a register); / also waits on a divider that forms one
// quotient bit per cycle, unless the divisor is zero. Unknown characters,
// operators that find fewer than two operands and anything after an error
// retire from the idle state. A final character waits at the head of the
// queue while an unread result sits in the output register. The stack is
// a memory with a registered read port and needs no clearing after reset;
// full rises only when the queue is full.
module postfix_hex_byte_evaluator_unit #(
    parameter int STACK_DEPTH = pfx_pkg::PFX_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pfx_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output pfx_pkg::t_out_item o_out_item
);
    import pfx_pkg::*;

    logic w_q_wr, w_q_rd, w_q_valid;
    t_cmd w_wr_cmd, w_rd_cmd;

    // Classify and pair digits; enqueue only work the back end must see
    pfx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_item (i_in_item),
        .i_q_full  (full),
        .o_q_wr    (w_q_wr),
        .o_cmd     (w_wr_cmd)
    );

    // Decouple the two ends so either may stall on its own
    pfx_queue #(
        .DEPTH (PFX_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_q_wr),
        .i_wr_cmd (w_wr_cmd),
        .i_rd     (w_q_rd),
        .o_full   (full),
        .o_valid  (w_q_valid),
        .o_rd_cmd (w_rd_cmd)
    );

    // Stack, arithmetic and the result register
    pfx_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_cmd      (w_rd_cmd),
        .o_q_rd     (w_q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_item (o_out_item)
    );

endmodule
